FILE: rtl/nps_pkg.sv
// nps_pkg: shared constants, types and the cosine table of the nearest point search
// no dependencies; imported by nps_dist, nearest_point_search, nps_checker and tb_top
package nps_pkg;

	localparam int unsigned POINT_DEPTH = 16384;
	localparam int unsigned ADDR_W      = $clog2(POINT_DEPTH);
	localparam int unsigned CNT_W       = $clog2(POINT_DEPTH + 1);
	localparam int unsigned PCOUNT_W    = 15;
	localparam int unsigned LAT_W       = 24;
	localparam int unsigned LON_W       = 25;
	localparam int unsigned POINT_W     = LAT_W + LON_W;
	localparam int unsigned DIST_W      = 50;

	localparam int unsigned COS_ENTRIES    = 1024;
	localparam int unsigned COS_IDX_W      = $clog2(COS_ENTRIES);
	localparam int unsigned COS_W          = 15;
	localparam int unsigned COS_LAST_ANGLE = 720;
	localparam int unsigned COS_STEPS      = 1440;
	localparam int unsigned COS_SHIFT      = 13;
	localparam int unsigned PROJ_SHIFT     = 15;
	localparam logic [63:0] PI_Q30         = 64'd3373259426;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam int unsigned TAYLOR_TERMS = 12;
	localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
		64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
	};

	typedef logic [COS_ENTRIES-1:0][COS_W-1:0] cos_rom_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] index;
		logic [DIST_W-1:0] dsq;
	} dist_res_t;

	// cos(k/8 degree) in unsigned q0.15 from a truncating q30 taylor series
	function automatic cos_rom_t build_cos_rom();
		cos_rom_t           rom;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        c;
		for (int k = 0; k < COS_ENTRIES; k++) begin
			if (k > COS_LAST_ANGLE) begin
				rom[k] = '0;
			end else begin
				x    = (64'(k) * PI_Q30) / COS_STEPS;
				x2   = (x * x) >> 30;
				term = 64'd1 << 30;
				sum  = $signed(term);
				for (int n = 1; n <= TAYLOR_TERMS; n++) begin
					term = ((term * x2) >> 30) / TAYLOR_DIV[n];
					if (n % 2 == 1)
						sum = sum - $signed(term);
					else
						sum = sum + $signed(term);
				end
				if (sum < 0)
					sum = '0;
				c = ($unsigned(sum) + 64'd16384) >> 15;
				if (c > 64'd32767)
					c = 64'd32767;
				rom[k] = c[COS_W-1:0];
			end
		end
		return rom;
	endfunction

	localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

FILE: rtl/nps_ram.sv
// nps_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module nps_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

FILE: rtl/nps_dist.sv
// nps_dist: distance pipeline from a stored point and the query to the squared distance
// depends on nps_pkg (cosine table, widths, dist_res_t)
module nps_dist (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               rd_valid,
	input  logic [nps_pkg::ADDR_W-1:0]         rd_index,
	input  logic [nps_pkg::POINT_W-1:0]        rd_data,
	input  logic signed [nps_pkg::LAT_W-1:0]   qlat,
	input  logic signed [nps_pkg::LON_W-1:0]   qlon,
	output nps_pkg::dist_res_t                 res
);
	import nps_pkg::*;

	logic signed [LAT_W-1:0]     plat;
	logic signed [LON_W-1:0]     plon;
	logic signed [LAT_W:0]       lat_sum;
	logic [LAT_W-1:0]            mean;
	logic [LAT_W-1:0]            amean;
	logic [LAT_W-COS_SHIFT-1:0]  idx_raw;
	logic [COS_IDX_W-1:0]        cos_idx;
	logic signed [LAT_W:0]       dlat;
	logic signed [LON_W:0]       dlon;

	logic                        v_s2;
	logic [ADDR_W-1:0]           pidx_s2;
	logic [COS_W-1:0]            cos_s2;
	logic signed [LAT_W:0]       dlat_s2;
	logic signed [LON_W:0]       dlon_s2;

	logic signed [LON_W+COS_W+1:0] prod;
	logic [LAT_W:0]              dlat_neg;

	logic                        v_s3;
	logic [ADDR_W-1:0]           pidx_s3;
	logic signed [LON_W+1:0]     proj_s3;
	logic [LAT_W-1:0]            ulat_s3;

	logic [LON_W+1:0]            proj_neg;
	logic [LON_W-1:0]            ulon;

	logic                        v_s4;
	logic [ADDR_W-1:0]           pidx_s4;
	logic [2*LAT_W-1:0]          sqlat_s4;
	logic [2*LON_W-1:0]          sqlon_s4;

	logic [DIST_W:0]             dsum;

	assign plat    = rd_data[POINT_W-1:LON_W];
	assign plon    = rd_data[LON_W-1:0];
	assign lat_sum = {plat[LAT_W-1], plat} + {qlat[LAT_W-1], qlat};
	assign mean    = lat_sum[LAT_W:1];
	assign amean   = mean[LAT_W-1] ? (~mean + LAT_W'(1)) : mean;
	assign idx_raw = amean[LAT_W-1:COS_SHIFT];
	assign cos_idx = (32'(idx_raw) >= COS_ENTRIES) ? COS_IDX_W'(COS_ENTRIES - 1)
		: COS_IDX_W'(idx_raw);
	assign dlat    = {plat[LAT_W-1], plat} - {qlat[LAT_W-1], qlat};
	assign dlon    = {plon[LON_W-1], plon} - {qlon[LON_W-1], qlon};

	assign prod     = dlon_s2 * $signed({1'b0, cos_s2});
	assign dlat_neg = ~dlat_s2 + (LAT_W+1)'(1);

	assign proj_neg = ~proj_s3 + (LON_W+2)'(1);
	assign ulon     = proj_s3[LON_W+1] ? proj_neg[LON_W-1:0] : proj_s3[LON_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= rd_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		pidx_s2  <= rd_index;
		cos_s2   <= COS_ROM[cos_idx];
		dlat_s2  <= dlat;
		dlon_s2  <= dlon;

		pidx_s3  <= pidx_s2;
		proj_s3  <= prod[LON_W+COS_W+1:PROJ_SHIFT];
		ulat_s3  <= dlat_s2[LAT_W] ? dlat_neg[LAT_W-1:0] : dlat_s2[LAT_W-1:0];

		pidx_s4  <= pidx_s3;
		sqlat_s4 <= ulat_s3 * ulat_s3;
		sqlon_s4 <= ulon * ulon;
	end

	// saturate to the distance width
	assign dsum = (DIST_W+1)'(sqlat_s4) + (DIST_W+1)'(sqlon_s4);

	assign res.valid = v_s4;
	assign res.index = pidx_s4;
	assign res.dsq   = dsum[DIST_W] ? {DIST_W{1'b1}} : dsum[DIST_W-1:0];

endmodule

FILE: rtl/nearest_point_search.sv
// nearest_point_search: point table with a linear nearest point scan
// depends on nps_pkg, nps_ram and nps_dist
//
// channel   signals                                        transfer
// command   start, cmd, entry_index, latitude, longitude   start & !busy
// result    done, nearest_index, nearest_distance_sq, found  done, one cycle
// config    cfg_we, cfg_wdata                              cfg_we
//
// a point write goes into the table at its transfer; a query scans point_count
// entries, with point_count capped at the table depth (no scan when it is 0),
// one ram read per stored point through the single read port
// busy is high in the scan, drain and report states; results cannot stall
// reset clears control and point_count; the point table is not cleared
module nearest_point_search (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                cmd,
	input  logic [13:0]                         entry_index,
	input  logic signed [nps_pkg::LAT_W-1:0]    latitude,
	input  logic signed [nps_pkg::LON_W-1:0]    longitude,
	input  logic                                cfg_we,
	input  logic [nps_pkg::PCOUNT_W-1:0]        cfg_wdata,
	output logic                                done,
	output logic [13:0]                         nearest_index,
	output logic [nps_pkg::DIST_W-1:0]          nearest_distance_sq,
	output logic                                found
);
	import nps_pkg::*;

	state_t                  state_q;
	state_t                  state_d;
	logic [PCOUNT_W-1:0]     point_count_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_sat;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [LAT_W-1:0] qlat_q;
	logic signed [LON_W-1:0] qlon_q;
	logic                    accept;
	logic                    ram_we;
	logic                    rd_en;
	logic [ADDR_W-1:0]       raddr;
	logic [POINT_W-1:0]      rdata;
	logic                    v_s1;
	logic [ADDR_W-1:0]       pidx_s1;
	logic                    scan_last;
	logic                    pipe_busy;
	dist_res_t               res;
	logic [ADDR_W-1:0]       best_idx_q;
	logic [DIST_W-1:0]       best_d_q;
	logic                    found_q;

	// stages two and three of the distance pipeline still hold items
	logic [1:0] pend_q;
	logic       u_dist_pending;
	assign u_dist_pending = |pend_q;

	assign accept    = start && !busy;
	assign ram_we    = accept && (cmd == CMD_WRITE) && (32'(entry_index) < POINT_DEPTH);
	assign count_sat = (32'(point_count_q) > POINT_DEPTH) ? CNT_W'(POINT_DEPTH)
		: CNT_W'(point_count_q);
	assign raddr     = cnt_q[ADDR_W-1:0];
	assign scan_last = (cnt_q + CNT_W'(1)) == count_q;
	assign pipe_busy = v_s1 || res.valid;

	nps_ram #(
		.WIDTH(POINT_W),
		.DEPTH(POINT_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(entry_index[ADDR_W-1:0]),
		.wdata({latitude, longitude}),
		.re   (rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	nps_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_valid(v_s1),
		.rd_index(pidx_s1),
		.rd_data (rdata),
		.qlat    (qlat_q),
		.qlon    (qlon_q),
		.res     (res)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_QUERY)
					state_d = (count_sat == '0) ? ST_REPORT : ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// the drain state is entered in the cycle after the last read
				if (!pipe_busy && !u_dist_pending)
					state_d = ST_REPORT;
			end
			ST_REPORT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy  = 1'b1;
		done  = 1'b0;
		rd_en = 1'b0;
		case (state_q)
			ST_IDLE:   busy  = 1'b0;
			ST_SCAN:   rd_en = 1'b1;
			ST_DRAIN:  busy  = 1'b1;
			ST_REPORT: done  = 1'b1;
			default:   busy  = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			point_count_q <= '0;
			count_q       <= '0;
			cnt_q         <= '0;
			v_s1          <= 1'b0;
			pend_q        <= '0;
			found_q       <= 1'b0;
			best_idx_q    <= '0;
			best_d_q      <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= rd_en;
			pend_q  <= {pend_q[0], v_s1};
			if (cfg_we)
				point_count_q <= cfg_wdata;
			if (accept && cmd == CMD_QUERY) begin
				count_q    <= count_sat;
				cnt_q      <= '0;
				found_q    <= 1'b0;
				best_idx_q <= '0;
				best_d_q   <= '0;
			end else begin
				if (rd_en)
					cnt_q <= cnt_q + CNT_W'(1);
				// first minimum wins on ties
				if (res.valid && (!found_q || res.dsq < best_d_q)) begin
					found_q    <= 1'b1;
					best_idx_q <= res.index;
					best_d_q   <= res.dsq;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pidx_s1 <= raddr;
		if (accept && cmd == CMD_QUERY) begin
			qlat_q <= latitude;
			qlon_q <= longitude;
		end
	end

	assign nearest_index       = best_idx_q;
	assign nearest_distance_sq = best_d_q;
	assign found               = found_q;

endmodule

FILE: tb/nps_checker.sv
`timescale 1ns / 100ps
// nps_checker: predicts and checks every query result of nearest_point_search
// watches the command, config and result ports; widths and codes come from nps_pkg
module nps_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic                                cmd,
	input  logic [13:0]                         entry_index,
	input  logic signed [nps_pkg::LAT_W-1:0]    latitude,
	input  logic signed [nps_pkg::LON_W-1:0]    longitude,
	input  logic                                cfg_we,
	input  logic [nps_pkg::PCOUNT_W-1:0]        cfg_wdata,
	input  logic                                done,
	input  logic [13:0]                         nearest_index,
	input  logic [nps_pkg::DIST_W-1:0]          nearest_distance_sq,
	input  logic                                found,
	output int                                  fail_count,
	output int                                  pending
);
	import nps_pkg::*;

	localparam longint unsigned PI_Q30_VAL   = 64'd3373259426;
	localparam longint unsigned STEPS_180    = 64'd1440;
	localparam int              LAST_ANGLE   = 720;
	localparam int              SERIES_TERMS = 12;
	localparam longint unsigned COS_TOP      = 64'd1023;
	localparam longint unsigned DIST_CAP     = (64'd1 << DIST_W) - 64'd1;
	localparam int              ANSWER_SLOTS = 4;

	typedef struct packed {
		logic signed [LAT_W-1:0] lat;
		logic signed [LON_W-1:0] lon;
	} point_t;

	typedef struct packed {
		logic [13:0]       index;
		logic [DIST_W-1:0] dsq;
		logic              found;
	} answer_t;

	point_t            stored_pts [POINT_DEPTH];
	logic [COS_W-1:0]  cos_q15 [COS_ENTRIES];
	logic [PCOUNT_W-1:0] search_count;
	answer_t           expected_answers [ANSWER_SLOTS];
	int                put_count = 0;
	int                take_count = 0;
	int                failures = 0;
	int                waiting = 0;

	assign fail_count = failures;
	assign pending    = waiting;

	// cos of k/8 degree in unsigned q0.15, truncating q30 taylor series
	function automatic logic [COS_W-1:0] cos_eighth_degree(input int k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		if (k > LAST_ANGLE)
			return '0;
		x    = longint'(k) * PI_Q30_VAL / STEPS_180;
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		acc  = longint'(term);
		for (int m = 1; m <= SERIES_TERMS; m++) begin
			term = ((term * x2) >> 30) / longint'((2 * m - 1) * (2 * m));
			if (m % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		acc = (acc + 16384) >>> 15;
		if (acc > 32767)
			acc = 32767;
		return acc[COS_W-1:0];
	endfunction

	function automatic answer_t nearest_of(input logic signed [LAT_W-1:0] qlat,
			input logic signed [LON_W-1:0] qlon);
		answer_t         best;
		longint          plat;
		longint          plon;
		longint          mid;
		longint          dlat;
		longint          dlon;
		longint          proj;
		longint unsigned idx;
		longint unsigned d;
		int              limit;
		best  = '0;
		limit = (search_count > POINT_DEPTH) ? POINT_DEPTH : int'(search_count);
		for (int i = 0; i < limit; i++) begin
			plat = $signed(stored_pts[i].lat);
			plon = $signed(stored_pts[i].lon);
			mid  = (longint'(qlat) + plat) >>> 1;
			idx  = (mid < 0) ? -mid : mid;
			idx  = idx >> 13;
			if (idx > COS_TOP)
				idx = COS_TOP;
			dlat = plat - longint'(qlat);
			dlon = plon - longint'(qlon);
			proj = (dlon * longint'(cos_q15[idx])) >>> 15;
			if (dlat < 0)
				dlat = -dlat;
			if (proj < 0)
				proj = -proj;
			d = dlat * dlat + proj * proj;
			if (d > DIST_CAP)
				d = DIST_CAP;
			if (!best.found || d < best.dsq) begin
				best.index = i[13:0];
				best.dsq   = d[DIST_W-1:0];
				best.found = 1'b1;
			end
		end
		return best;
	endfunction

	task automatic check_field(input string what, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			failures++;
			$display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	initial begin
		for (int k = 0; k < COS_ENTRIES; k++)
			cos_q15[k] = cos_eighth_degree(k);
	end

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			search_count <= '0;
			put_count = 0;
			take_count = 0;
			waiting <= 0;
		end else begin
			if (cfg_we)
				search_count <= cfg_wdata;
			if (start && !busy) begin
				if (cmd == CMD_WRITE) begin
					stored_pts[entry_index] = '{lat: latitude, lon: longitude};
				end else begin
					expected_answers[put_count % ANSWER_SLOTS] = nearest_of(latitude, longitude);
					put_count++;
				end
			end
			if (done) begin
				if (put_count == take_count) begin
					failures++;
					$display("%0t unexpected result: expected none actual index %0d dist %0d found %0d",
						$time, nearest_index, nearest_distance_sq, found);
				end else begin
					want = expected_answers[take_count % ANSWER_SLOTS];
					take_count++;
					check_field("nearest_index", want.index, nearest_index);
					check_field("nearest_distance_sq", want.dsq, nearest_distance_sq);
					check_field("found", want.found, found);
				end
			end
			waiting <= put_count - take_count;
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for nearest_point_search
// drives point writes, queries and point_count; nps_checker does the checking
module tb_top;
	import nps_pkg::*;

	localparam int LAT_SPAN      = 5898240;
	localparam int LON_SPAN      = 11796480;
	localparam int RANDOM_ITEMS  = 100;
	localparam int MIN_QUERIES   = 16;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 40000;
	localparam int KEPT_POINTS   = 64;

	localparam logic signed [LAT_W-1:0] LAT_MAX    = 24'sd5898240;
	localparam logic signed [LAT_W-1:0] LAT_MIN    = -24'sd5898240;
	localparam logic signed [LAT_W-1:0] LAT_PAT_LO = 24'h800000;
	localparam logic signed [LAT_W-1:0] LAT_PAT_HI = 24'h7FFFFF;
	localparam logic signed [LON_W-1:0] LON_MAX    = 25'sd11796480;
	localparam logic signed [LON_W-1:0] LON_MIN    = -25'sd11796480;
	localparam logic signed [LON_W-1:0] LON_PAT_LO = 25'h1000000;
	localparam logic signed [LON_W-1:0] LON_PAT_HI = 25'h0FFFFFF;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    cmd;
	logic [13:0]             entry_index;
	logic signed [LAT_W-1:0] latitude;
	logic signed [LON_W-1:0] longitude;
	logic                    cfg_we;
	logic [PCOUNT_W-1:0]     cfg_wdata;
	logic                    done;
	logic [13:0]             nearest_index;
	logic [DIST_W-1:0]       nearest_distance_sq;
	logic                    found;
	int                      fail_count;
	int                      pending;

	logic signed [LAT_W-1:0] sent_lat [KEPT_POINTS] = '{default: '0};
	logic signed [LON_W-1:0] sent_lon [KEPT_POINTS] = '{default: '0};
	int                      rand_items;
	int                      rand_queries;

	nearest_point_search dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.cmd                 (cmd),
		.entry_index         (entry_index),
		.latitude            (latitude),
		.longitude           (longitude),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.done                (done),
		.nearest_index       (nearest_index),
		.nearest_distance_sq (nearest_distance_sq),
		.found               (found)
	);

	nps_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.cmd                 (cmd),
		.entry_index         (entry_index),
		.latitude            (latitude),
		.longitude           (longitude),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.done                (done),
		.nearest_index       (nearest_index),
		.nearest_distance_sq (nearest_distance_sq),
		.found               (found),
		.fail_count          (fail_count),
		.pending             (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// mostly in range, sometimes any bit pattern
	function automatic logic signed [LAT_W-1:0] any_lat();
		int v;
		if ($urandom_range(4) == 0) begin
			v = $urandom();
		end else begin
			v = $urandom_range(2 * LAT_SPAN);
			v = v - LAT_SPAN;
		end
		return v[LAT_W-1:0];
	endfunction

	function automatic logic signed [LON_W-1:0] any_lon();
		int v;
		if ($urandom_range(4) == 0) begin
			v = $urandom();
		end else begin
			v = $urandom_range(2 * LON_SPAN);
			v = v - LON_SPAN;
		end
		return v[LON_W-1:0];
	endfunction

	task automatic send(input logic c, input logic [13:0] slot,
			input logic signed [LAT_W-1:0] lat, input logic signed [LON_W-1:0] lon,
			input int gap);
		start       <= 1'b1;
		cmd         <= c;
		entry_index <= slot;
		latitude    <= lat;
		longitude   <= lon;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every query has answered
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_count(input logic [PCOUNT_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// some writes repeat an earlier point to make ties
	task automatic store_point(input int slot, input int gap);
		logic signed [LAT_W-1:0] la;
		logic signed [LON_W-1:0] lo;
		int                      src;
		la = any_lat();
		lo = any_lon();
		if (slot > 0 && slot < KEPT_POINTS && $urandom_range(4) == 0) begin
			src = $urandom_range(slot - 1);
			la  = sent_lat[src];
			lo  = sent_lon[src];
		end
		if (slot < KEPT_POINTS) begin
			sent_lat[slot] = la;
			sent_lon[slot] = lo;
		end
		send(CMD_WRITE, slot[13:0], la, lo, gap);
	endtask

	task automatic query_around(input int n, input int gap);
		int k;
		int dl;
		int dn;
		k  = $urandom_range(n - 1);
		dl = $urandom_range(1 << $urandom_range(20));
		dn = $urandom_range(1 << $urandom_range(20));
		if ($urandom_range(1))
			dl = -dl;
		if ($urandom_range(1))
			dn = -dn;
		send(CMD_QUERY, 14'($urandom()), LAT_W'(sent_lat[k] + dl), LON_W'(sent_lon[k] + dn), gap);
	endtask

	initial begin
		int   n;
		int   ops;
		int   waited;
		logic calm;
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = CMD_WRITE;
		entry_index = '0;
		latitude    = '0;
		longitude   = '0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// empty table
		set_count('0);
		send(CMD_QUERY, 14'd0, '0, '0, 0);

		send(CMD_WRITE, 14'd0, LAT_PAT_LO, LON_PAT_LO, 0);
		send(CMD_WRITE, 14'd1, LAT_MAX, LON_MAX, 0);
		send(CMD_WRITE, 14'd2, LAT_MIN, LON_MIN, 2);
		send(CMD_WRITE, 14'd3, LAT_PAT_HI, LON_PAT_HI, 0);
		send(CMD_WRITE, 14'd4, '0, '0, 0);
		send(CMD_WRITE, 14'd5, '0, '0, 0);
		send(CMD_WRITE, 14'd16383, LAT_MAX, LON_MIN, 0);

		// saturated distance, then cosine index past the table end
		set_count(PCOUNT_W'(1));
		send(CMD_QUERY, 14'd0, LAT_PAT_HI, LON_PAT_HI, 0);
		send(CMD_QUERY, 14'd16383, LAT_PAT_LO, 25'sd12345, 3);

		// tie between slots 4 and 5, exact hits, poles and mid latitudes
		set_count(PCOUNT_W'(6));
		send(CMD_QUERY, 14'd0, '0, '0, 0);
		send(CMD_QUERY, 14'd0, LAT_MAX, LON_MAX, 0);
		send(CMD_QUERY, 14'd0, LAT_PAT_HI, 25'sd3, 1);
		send(CMD_QUERY, 14'd0, LAT_MIN, 25'sd1, 0);
		send(CMD_QUERY, 14'd0, 24'sd2949120, -25'sd5898240, 0);

		rand_items   = 0;
		rand_queries = 0;
		while (rand_items < RANDOM_ITEMS || rand_queries < MIN_QUERIES) begin
			n    = ($urandom_range(4) == 0) ? $urandom_range(KEPT_POINTS, 25) : $urandom_range(24, 1);
			calm = ($urandom_range(3) == 0);
			set_count(PCOUNT_W'(n));
			for (int s = 0; s < n; s++) begin
				store_point(s, calm ? 0 : gap_len());
				rand_items++;
			end
			ops = $urandom_range(12, 4);
			for (int j = 0; j < ops; j++) begin
				if ($urandom_range(9) < 6) begin
					if ($urandom_range(3) != 0)
						query_around(n, calm ? 0 : gap_len());
					else
						send(CMD_QUERY, 14'($urandom()), any_lat(), any_lon(), calm ? 0 : gap_len());
					rand_queries++;
				end else if ($urandom_range(1)) begin
					store_point($urandom_range(n - 1), calm ? 0 : gap_len());
				end else begin
					store_point($urandom_range(16383), calm ? 0 : gap_len());
				end
				rand_items++;
			end
		end

		start <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
rtl/nps_pkg.sv
rtl/nps_ram.sv
rtl/nps_dist.sv
rtl/nearest_point_search.sv
tb/nps_checker.sv
tb/tb_top.sv
